// ----- design/pmlu_pkg.sv -----
`default_nettype none

package pmlu_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int AGE_W   = 32;
    localparam int SPEED_W = 24;
    localparam int STEP_W  = 16;
    localparam int FRAC_W  = 16;
    localparam int CFG_W   = 32;

    // derived datapath widths
    localparam int DIST_W = SPEED_W;            // (speed * step) >> 16 stays below 2^24
    localparam int VEC_W  = POS_W + 1;          // exact difference to the pivot
    localparam int MAG_W  = POS_W;              // magnitude after optional halving
    localparam int SQ_W   = 2 * MAG_W;          // square and sum of squares
    localparam int ROOT_W = SQ_W / 2;
    localparam int PROD_W = MAG_W + DIST_W;     // magnitude times distance
    localparam int QUO_W  = DIST_W;             // per-axis move never exceeds distance
    localparam int EXT_W  = POS_W + 2;          // position add before clamping

    // pipeline depths of the iterative units
    localparam int SQRT_BITS   = 2;
    localparam int SQRT_STAGES = ROOT_W / SQRT_BITS;
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = QUO_W / DIV_BITS;

    localparam int AXES = 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIVOT_X,
        CFG_PIVOT_Y,
        CFG_PIVOT_Z,
        CFG_LOOPING,
        CFG_MOTION_MODE
    } cfg_index_t;

    // motion modes; the unused code behaves as burst
    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_DROP   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPREAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BURST  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // per-particle data carried down the pipeline
    typedef struct packed {
        logic [AXES-1:0][POS_W-1:0] pos;
        logic [AXES-1:0][POS_W-1:0] spawn;
        logic [AGE_W-1:0]           new_age;
        logic                       expired;
        logic                       last;
        logic [DIST_W-1:0]          step_dist;
        logic [AXES-1:0][MAG_W-1:0] mag;
        logic [AXES-1:0]            neg;
        logic                       zero;
    } side_t;

endpackage

`default_nettype wire

// ----- design/pmlu_sqrt.sv -----
`default_nettype none

module pmlu_sqrt (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic [pmlu_pkg::SQ_W-1:0]   radicand,
    output logic      [pmlu_pkg::ROOT_W-1:0] root
);

    localparam int REM_W = pmlu_pkg::ROOT_W + 2;

    typedef struct packed {
        logic [REM_W-1:0]            rem;
        logic [pmlu_pkg::ROOT_W-1:0] root;
        logic [pmlu_pkg::SQ_W-1:0]   rad;
    } sq_state_t;

    // a few digit-by-digit steps of the restoring square root
    function automatic sq_state_t sqrt_stage(input sq_state_t s);
        sq_state_t        t;
        logic [REM_W+1:0] r;
        logic [REM_W+1:0] trial;
        t = s;
        for (int i = 0; i < pmlu_pkg::SQRT_BITS; i++) begin
            r     = {t.rem, t.rad[pmlu_pkg::SQ_W-1 -: 2]};
            trial = {2'b00, t.root, 2'b01};
            if (r >= trial) begin
                t.rem  = REM_W'(r - trial);
                t.root = {t.root[pmlu_pkg::ROOT_W-2:0], 1'b1};
            end
            else begin
                t.rem  = r[REM_W-1:0];
                t.root = {t.root[pmlu_pkg::ROOT_W-2:0], 1'b0};
            end
            t.rad = {t.rad[pmlu_pkg::SQ_W-3:0], 2'b00};
        end
        return t;
    endfunction

    sq_state_t st_reg  [pmlu_pkg::SQRT_STAGES];
    sq_state_t st_next [pmlu_pkg::SQRT_STAGES];

    // stage inputs
    always_comb
    begin
        st_next[0] = sqrt_stage('{rem: '0, root: '0, rad: radicand});
        for (int k = 1; k < pmlu_pkg::SQRT_STAGES; k++)
        begin
            st_next[k] = sqrt_stage(st_reg[k-1]);
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < pmlu_pkg::SQRT_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign root = st_reg[pmlu_pkg::SQRT_STAGES-1].root;

endmodule

`default_nettype wire

// ----- design/pmlu_div.sv -----
`default_nettype none

module pmlu_div (
    input  wire logic                                            clk,
    input  wire logic                                            en,
    input  wire logic [pmlu_pkg::AXES-1:0][pmlu_pkg::PROD_W-1:0] dividend,
    input  wire logic [pmlu_pkg::ROOT_W-1:0]                     divisor,
    output logic      [pmlu_pkg::AXES-1:0][pmlu_pkg::QUO_W-1:0]  quotient
);

    localparam int REM_W = pmlu_pkg::ROOT_W;

    typedef struct packed {
        logic [REM_W-1:0]           rem;
        logic [pmlu_pkg::QUO_W-1:0] low;
        logic [pmlu_pkg::QUO_W-1:0] quo;
    } dv_lane_t;

    typedef struct packed {
        logic [pmlu_pkg::AXES-1:0] [$bits(dv_lane_t)-1:0] lane;
        logic [REM_W-1:0]                                 div;
    } dv_state_t;

    // a few restoring division steps on all lanes with a shared divisor
    function automatic dv_state_t div_stage(input dv_state_t s);
        dv_state_t        t;
        dv_lane_t         l;
        logic [REM_W:0]   r;
        t = s;
        for (int a = 0; a < pmlu_pkg::AXES; a++) begin
            l = dv_lane_t'(t.lane[a]);
            for (int i = 0; i < pmlu_pkg::DIV_BITS; i++) begin
                r = {l.rem, l.low[pmlu_pkg::QUO_W-1]};
                if (r >= {1'b0, t.div}) begin
                    l.rem = REM_W'(r - {1'b0, t.div});
                    l.quo = {l.quo[pmlu_pkg::QUO_W-2:0], 1'b1};
                end
                else begin
                    l.rem = r[REM_W-1:0];
                    l.quo = {l.quo[pmlu_pkg::QUO_W-2:0], 1'b0};
                end
                l.low = {l.low[pmlu_pkg::QUO_W-2:0], 1'b0};
            end
            t.lane[a] = l;
        end
        return t;
    endfunction

    dv_state_t st_reg  [pmlu_pkg::DIV_STAGES];
    dv_state_t st_next [pmlu_pkg::DIV_STAGES];
    dv_state_t st_init;
    dv_lane_t  init_lane;
    dv_lane_t  out_lane;

    // upper dividend bits form the starting remainder
    always_comb
    begin
        st_init.div = divisor;
        for (int a = 0; a < pmlu_pkg::AXES; a++)
        begin
            init_lane.rem   = dividend[a][pmlu_pkg::PROD_W-1 -: REM_W];
            init_lane.low   = dividend[a][pmlu_pkg::QUO_W-1:0];
            init_lane.quo   = '0;
            st_init.lane[a] = init_lane;
        end
        st_next[0] = div_stage(st_init);
        for (int k = 1; k < pmlu_pkg::DIV_STAGES; k++)
        begin
            st_next[k] = div_stage(st_reg[k-1]);
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < pmlu_pkg::DIV_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // quotient bits out of the last stage
    always_comb
    begin
        for (int a = 0; a < pmlu_pkg::AXES; a++)
        begin
            out_lane    = dv_lane_t'(st_reg[pmlu_pkg::DIV_STAGES-1].lane[a]);
            quotient[a] = out_lane.quo;
        end
    end

endmodule

`default_nettype wire

// ----- design/particle_motion_lifetime_update.sv -----
`default_nettype none

// Particle update pipeline: one particle word enters per cycle and passes the
// input stage, three direction stages, sixteen square root stages, one
// multiply stage, twelve divide stages and the output register. A
// full pipeline sustains one word per cycle; the whole pipeline holds while
// the output word waits, and bubbles travel with it. Configuration writes are
// always taken and should only be issued while no particle is in flight.
// all_dead is reported on the word marked final_particle and covers every
// particle since the previous final one.
module particle_motion_lifetime_update (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // particle input
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [pmlu_pkg::POS_W-1:0]  pos_x,
    input  wire logic signed [pmlu_pkg::POS_W-1:0]  pos_y,
    input  wire logic signed [pmlu_pkg::POS_W-1:0]  pos_z,
    input  wire logic [pmlu_pkg::AGE_W-1:0]         age,
    input  wire logic [pmlu_pkg::AGE_W-1:0]         lifetime,
    input  wire logic [pmlu_pkg::SPEED_W-1:0]       speed,
    input  wire logic signed [pmlu_pkg::POS_W-1:0]  spawn_x,
    input  wire logic signed [pmlu_pkg::POS_W-1:0]  spawn_y,
    input  wire logic signed [pmlu_pkg::POS_W-1:0]  spawn_z,
    input  wire logic [pmlu_pkg::STEP_W-1:0]        step_time,
    input  wire logic                               final_particle,
    // result output
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [pmlu_pkg::POS_W-1:0]       new_x,
    output logic signed [pmlu_pkg::POS_W-1:0]       new_y,
    output logic signed [pmlu_pkg::POS_W-1:0]       new_z,
    output logic [pmlu_pkg::AGE_W-1:0]              new_age,
    output logic                                    is_last,
    output logic                                    all_dead,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pmlu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pmlu_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AXES     = pmlu_pkg::AXES;
    localparam int POS_W    = pmlu_pkg::POS_W;
    localparam int VEC_W    = pmlu_pkg::VEC_W;
    localparam int MAG_W    = pmlu_pkg::MAG_W;
    localparam int SQ_W     = pmlu_pkg::SQ_W;
    localparam int EXT_W    = pmlu_pkg::EXT_W;
    localparam int DIST_W   = pmlu_pkg::DIST_W;
    localparam int QUO_W    = pmlu_pkg::QUO_W;
    localparam int DPROD_W  = pmlu_pkg::SPEED_W + pmlu_pkg::STEP_W;
    localparam int E_IDX    = pmlu_pkg::SQRT_STAGES;
    localparam int LINE_LEN = pmlu_pkg::SQRT_STAGES + 1 + pmlu_pkg::DIV_STAGES;

    // clamp a widened sum to the signed position range
    function automatic logic [POS_W-1:0] sat_pos(input logic [EXT_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v[EXT_W-1] && !(&v[EXT_W-2:POS_W-1]))
            r = {1'b1, {(POS_W-1){1'b0}}};
        else if (!v[EXT_W-1] && (|v[EXT_W-2:POS_W-1]))
            r = {1'b0, {(POS_W-1){1'b1}}};
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

    logic en;

    // configuration registers and the alive flag
    logic [AXES-1:0][POS_W-1:0]      pivot_reg;
    logic                            looping_reg;
    logic [pmlu_pkg::MODE_W-1:0]     mode_reg;
    logic                            alive_seen_reg;

    // pipeline registers
    logic                            a_valid_reg;
    pmlu_pkg::side_t                 a_side_reg;
    logic [AXES-1:0][VEC_W-1:0]      a_vec_reg;
    logic                            b_valid_reg;
    pmlu_pkg::side_t                 b_side_reg;
    logic                            c_valid_reg;
    pmlu_pkg::side_t                 c_side_reg;
    logic [AXES-1:0][SQ_W-1:0]       c_sq_reg;
    logic                            d_valid_reg;
    pmlu_pkg::side_t                 d_side_reg;
    logic [SQ_W-1:0]                 d_sum_reg;
    logic                            line_valid_reg [LINE_LEN];
    pmlu_pkg::side_t                 line_side_reg  [LINE_LEN];
    logic [AXES-1:0][pmlu_pkg::PROD_W-1:0] e_prod_reg;
    logic [pmlu_pkg::ROOT_W-1:0]     e_len_reg;
    logic                            out_valid_reg;
    logic [AXES-1:0][POS_W-1:0]      out_pos_reg;
    logic [pmlu_pkg::AGE_W-1:0]      out_age_reg;
    logic                            out_last_reg;
    logic                            out_dead_reg;

    // next values
    pmlu_pkg::side_t                 a_side_next;
    logic [AXES-1:0][VEC_W-1:0]      a_vec_next;
    logic [DPROD_W-1:0]              dist_prod;
    logic [pmlu_pkg::AGE_W:0]        age_sum;
    pmlu_pkg::side_t                 b_side_next;
    logic [VEC_W-1:0]                vabs;
    logic [VEC_W-1:0]                vsh;
    logic [VEC_W-1:0]                vmag;
    logic                            big;
    logic [pmlu_pkg::ROOT_W-1:0]     sqrt_root;
    logic [AXES-1:0][QUO_W-1:0]      div_quo;
    pmlu_pkg::side_t                 f_side;
    logic [AXES-1:0][POS_W-1:0]      out_pos_next;
    logic [EXT_W-1:0]                move_sum;
    logic [QUO_W:0]                  signed_move;
    logic                            respawn;
    logic                            alive;
    logic                            f_valid;

    assign en        = out_ready || !out_valid_reg;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_reg   <= '0;
            looping_reg <= 1'b0;
            mode_reg    <= pmlu_pkg::MODE_DROP;
        end
        else if (cfg_valid)
        begin
            unique case (pmlu_pkg::cfg_index_t'(cfg_index))
                pmlu_pkg::CFG_PIVOT_X:     pivot_reg[0] <= cfg_data;
                pmlu_pkg::CFG_PIVOT_Y:     pivot_reg[1] <= cfg_data;
                pmlu_pkg::CFG_PIVOT_Z:     pivot_reg[2] <= cfg_data;
                pmlu_pkg::CFG_LOOPING:     looping_reg  <= cfg_data[0];
                pmlu_pkg::CFG_MOTION_MODE: mode_reg     <= cfg_data[pmlu_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage a: distance, age, offset from pivot
    always_comb
    begin
        dist_prod = {{pmlu_pkg::STEP_W{1'b0}}, speed} * {{pmlu_pkg::SPEED_W{1'b0}}, step_time};
        age_sum   = {1'b0, age} + {{(pmlu_pkg::AGE_W + 1 - pmlu_pkg::STEP_W){1'b0}}, step_time};
        a_side_next           = '0;
        a_side_next.pos       = {pos_z, pos_y, pos_x};
        a_side_next.spawn     = {spawn_z, spawn_y, spawn_x};
        a_side_next.new_age   = age_sum[pmlu_pkg::AGE_W] ? '1 : age_sum[pmlu_pkg::AGE_W-1:0];
        a_side_next.expired   = a_side_next.new_age >= lifetime;
        a_side_next.last      = final_particle;
        a_side_next.step_dist = dist_prod[DPROD_W-1 -: DIST_W];
        for (int i = 0; i < AXES; i++)
        begin
            a_vec_next[i] = {a_side_next.pos[i][POS_W-1], a_side_next.pos[i]}
                          - {pivot_reg[i][POS_W-1], pivot_reg[i]};
        end
    end

    // stage b: common halving, magnitudes and signs
    always_comb
    begin
        b_side_next = a_side_reg;
        big = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            vabs = a_vec_reg[i][VEC_W-1] ? (~a_vec_reg[i] + 1'b1) : a_vec_reg[i];
            big  = big | vabs[VEC_W-1] | vabs[VEC_W-2];
        end
        for (int i = 0; i < AXES; i++)
        begin
            vsh  = big ? {a_vec_reg[i][VEC_W-1], a_vec_reg[i][VEC_W-1:1]} : a_vec_reg[i];
            vmag = vsh[VEC_W-1] ? (~vsh + 1'b1) : vsh;
            b_side_next.mag[i] = vmag[MAG_W-1:0];
            b_side_next.neg[i] = vsh[VEC_W-1];
        end
        b_side_next.zero = (b_side_next.mag == '0);
    end

    // front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg <= a_side_next;
            a_vec_reg  <= a_vec_next;
            b_side_reg <= b_side_next;
            c_side_reg <= b_side_reg;
            for (int i = 0; i < AXES; i++)
            begin
                c_sq_reg[i] <= {{MAG_W{1'b0}}, b_side_reg.mag[i]}
                             * {{MAG_W{1'b0}}, b_side_reg.mag[i]};
            end
            d_side_reg <= c_side_reg;
            d_sum_reg  <= c_sq_reg[0] + c_sq_reg[1] + c_sq_reg[2];
        end
    end

    // length of the direction vector
    pmlu_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (d_sum_reg),
        .root     (sqrt_root)
    );

    // side data line alongside the root, multiply and divide stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LINE_LEN; k++)
            begin
                line_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            line_valid_reg[0] <= d_valid_reg;
            for (int k = 1; k < LINE_LEN; k++)
            begin
                line_valid_reg[k] <= line_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_side_reg[0] <= d_side_reg;
            for (int k = 1; k < LINE_LEN; k++)
            begin
                line_side_reg[k] <= line_side_reg[k-1];
            end
            // stage e: scale each magnitude by the step distance
            for (int i = 0; i < AXES; i++)
            begin
                e_prod_reg[i] <= {{DIST_W{1'b0}}, line_side_reg[E_IDX-1].mag[i]}
                               * {{MAG_W{1'b0}}, line_side_reg[E_IDX-1].step_dist};
            end
            e_len_reg <= sqrt_root;
        end
    end

    // per-axis move = magnitude * distance / length
    pmlu_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (e_prod_reg),
        .divisor  (e_len_reg),
        .quotient (div_quo)
    );

    // final stage: apply motion, respawn and alive tracking
    always_comb
    begin
        f_side  = line_side_reg[LINE_LEN-1];
        f_valid = line_valid_reg[LINE_LEN-1];
        out_pos_next = f_side.pos;
        move_sum     = '0;
        signed_move  = '0;
        if (mode_reg == pmlu_pkg::MODE_DROP)
        begin
            move_sum = {{2{f_side.pos[1][POS_W-1]}}, f_side.pos[1]}
                     - {{(EXT_W - DIST_W){1'b0}}, f_side.step_dist};
            out_pos_next[1] = sat_pos(move_sum);
        end
        else if (!f_side.zero)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                signed_move = f_side.neg[i] ? (~{1'b0, div_quo[i]} + 1'b1) : {1'b0, div_quo[i]};
                move_sum = {{2{f_side.pos[i][POS_W-1]}}, f_side.pos[i]}
                         + {{(EXT_W - QUO_W - 1){signed_move[QUO_W]}}, signed_move};
                out_pos_next[i] = sat_pos(move_sum);
            end
        end
        respawn = looping_reg && f_side.expired;
        if (respawn)
        begin
            out_pos_next = f_side.spawn;
        end
        alive = !f_side.expired
             && (mode_reg != pmlu_pkg::MODE_DROP && mode_reg != pmlu_pkg::MODE_SPREAD
                 || !looping_reg);
    end

    // output register and alive accumulation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            alive_seen_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= f_valid;
            if (f_valid)
            begin
                if (f_side.last)
                    alive_seen_reg <= 1'b0;
                else if (alive)
                    alive_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pos_reg  <= out_pos_next;
            out_age_reg  <= respawn ? '0 : f_side.new_age;
            out_last_reg <= f_side.last;
            out_dead_reg <= f_side.last && !(alive_seen_reg || alive);
        end
    end

    assign out_valid = out_valid_reg;
    assign new_x     = out_pos_reg[0];
    assign new_y     = out_pos_reg[1];
    assign new_z     = out_pos_reg[2];
    assign new_age   = out_age_reg;
    assign is_last   = out_last_reg;
    assign all_dead  = out_dead_reg;

`ifndef SYNTHESIS
    // all_dead only ever accompanies the final word of a step
    a_dead_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_dead_reg |-> out_last_reg)
        else $error("all_dead set on a non-final word");

    // alive flag restarts after the final word of a step
    a_alive_clear: assert property (@(posedge clk) disable iff (!rst_n)
        en && f_valid && f_side.last |=> !alive_seen_reg)
        else $error("alive flag not cleared after final word");

    // a nonzero direction always yields a nonzero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_valid_reg[E_IDX] && !line_side_reg[E_IDX].zero |-> e_len_reg != '0)
        else $error("zero length for nonzero direction");

    // a respawned particle leaves with age zero
    a_respawn_age: assert property (@(posedge clk) disable iff (!rst_n)
        en && f_valid && respawn |=> out_age_reg == '0)
        else $error("respawned particle kept its age");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int POS_W     = pmlu_pkg::POS_W;
    localparam int AGE_W     = pmlu_pkg::AGE_W;
    localparam int SPEED_W   = pmlu_pkg::SPEED_W;
    localparam int STEP_W    = pmlu_pkg::STEP_W;
    localparam int FRAC_W    = pmlu_pkg::FRAC_W;
    localparam int MODE_W    = pmlu_pkg::MODE_W;
    localparam int CFG_IDX_W = pmlu_pkg::CFG_IDX_W;
    localparam int CFG_W     = pmlu_pkg::CFG_W;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 45;

    typedef struct {
        logic signed [POS_W-1:0] px, py, pz;
        logic [AGE_W-1:0]        age, life;
        logic [SPEED_W-1:0]      speed;
        logic signed [POS_W-1:0] sx, sy, sz;
        logic [STEP_W-1:0]       step;
        logic                    last;
    } particle_t;

    typedef struct {
        logic [POS_W-1:0] x, y, z;
        logic [AGE_W-1:0] age;
        logic             last;
        logic             dead;
    } update_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [AGE_W-1:0] age = '0, lifetime = '0;
    logic [SPEED_W-1:0] speed = '0;
    logic signed [POS_W-1:0] spawn_x = '0, spawn_y = '0, spawn_z = '0;
    logic [STEP_W-1:0] step_time = '0;
    logic final_particle = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [POS_W-1:0] new_x, new_y, new_z;
    logic [AGE_W-1:0] new_age;
    logic is_last, all_dead;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // shadow of the block's registers and step state
    longint pv_x, pv_y, pv_z;
    logic loop_en;
    logic [MODE_W-1:0] mode;
    logic alive_acc;

    update_t pending_updates[$];
    int errors = 0;
    int words_sent = 0;
    int words_checked = 0;
    int cycles = 0;
    logic no_idle = 1'b0;
    int stall_left = 0;

    particle_motion_lifetime_update dut (.*);

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // random receiver stalls
    always @(negedge clk)
    begin
        if (no_idle)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 30)
                stall_left = pick_gap();
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] res, cand;
        res = '0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = res | (64'd1 << i);
            if (cand * cand <= n)
                res = cand;
        end
        return res;
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint axis_shift(longint c, longint d, logic [63:0] len);
        logic [63:0] q;
        q = (64'(absl(c)) * 64'(d)) / len;
        return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    // expected update of one particle word
    function automatic update_t predict_update(particle_t p, output logic alive);
        update_t u;
        longint x, y, z, d, vx, vy, vz;
        logic [63:0] sum;
        logic [AGE_W:0] a;
        x = longint'(p.px);
        y = longint'(p.py);
        z = longint'(p.pz);
        d = longint'((64'(p.speed) * 64'(p.step)) >> FRAC_W);
        alive = 1'b0;
        if (mode == pmlu_pkg::MODE_DROP)
            y = clamp32(y - d);
        else
        begin
            vx = x - pv_x;
            vy = y - pv_y;
            vz = z - pv_z;
            if (absl(vx) >= 64'sd2147483648 || absl(vy) >= 64'sd2147483648 ||
                absl(vz) >= 64'sd2147483648)
            begin
                vx = vx >>> 1;
                vy = vy >>> 1;
                vz = vz >>> 1;
            end
            sum = 64'(absl(vx)) * 64'(absl(vx)) + 64'(absl(vy)) * 64'(absl(vy))
                + 64'(absl(vz)) * 64'(absl(vz));
            if (sum != 0)
            begin
                x = clamp32(x + axis_shift(vx, d, root64(sum)));
                y = clamp32(y + axis_shift(vy, d, root64(sum)));
                z = clamp32(z + axis_shift(vz, d, root64(sum)));
            end
        end
        a = {1'b0, p.age} + p.step;
        if (a[AGE_W]) a = {1'b0, {AGE_W{1'b1}}};
        if (loop_en && a[AGE_W-1:0] >= p.life)
        begin
            a = '0;
            x = longint'(p.sx);
            y = longint'(p.sy);
            z = longint'(p.sz);
        end
        else if (a[AGE_W-1:0] < p.life)
            alive = (mode >= pmlu_pkg::MODE_BURST) || !loop_en;
        u.x = x[31:0];
        u.y = y[31:0];
        u.z = z[31:0];
        u.age = a[AGE_W-1:0];
        u.last = p.last;
        u.dead = p.last ? !(alive_acc || alive) : 1'b0;
        return u;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h (word %0d)", what, got, want, words_checked);
    endtask

    // result checker
    always @(posedge clk)
    begin
        update_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_updates.size() == 0)
                report_mismatch("unexpected word", 64'(new_x), 64'd0);
            else
            begin
                w = pending_updates.pop_front();
                if (new_x !== w.x) report_mismatch("new_x", 64'(new_x), 64'(w.x));
                if (new_y !== w.y) report_mismatch("new_y", 64'(new_y), 64'(w.y));
                if (new_z !== w.z) report_mismatch("new_z", 64'(new_z), 64'(w.z));
                if (new_age !== w.age) report_mismatch("new_age", 64'(new_age), 64'(w.age));
                if (is_last !== w.last) report_mismatch("is_last", 64'(is_last), 64'(w.last));
                if (all_dead !== w.dead) report_mismatch("all_dead", 64'(all_dead), 64'(w.dead));
            end
            words_checked++;
        end
    end

    task automatic send_particle(particle_t p);
        int gap;
        logic alive;
        gap = no_idle ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
        age <= p.age; lifetime <= p.life; speed <= p.speed;
        spawn_x <= p.sx; spawn_y <= p.sy; spawn_z <= p.sz;
        step_time <= p.step; final_particle <= p.last;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pending_updates.push_back(predict_update(p, alive));
        if (p.last) alive_acc = 1'b0;
        else if (alive) alive_acc = 1'b1;
        words_sent++;
    endtask

    // sender holds off until the pipeline is empty
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(pmlu_pkg::cfg_index_t idx, logic [CFG_W-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            pmlu_pkg::CFG_PIVOT_X: pv_x = longint'(signed'(data));
            pmlu_pkg::CFG_PIVOT_Y: pv_y = longint'(signed'(data));
            pmlu_pkg::CFG_PIVOT_Z: pv_z = longint'(signed'(data));
            pmlu_pkg::CFG_LOOPING: loop_en = data[0];
            pmlu_pkg::CFG_MOTION_MODE: mode = data[MODE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic lp, logic [MODE_W-1:0] m);
        write_reg(pmlu_pkg::CFG_PIVOT_X, x);
        write_reg(pmlu_pkg::CFG_PIVOT_Y, y);
        write_reg(pmlu_pkg::CFG_PIVOT_Z, z);
        write_reg(pmlu_pkg::CFG_LOOPING, {31'd0, lp});
        write_reg(pmlu_pkg::CFG_MOTION_MODE, {30'd0, m});
    endtask

    function automatic particle_t make_particle(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [31:0] a,
                                                logic [31:0] l, logic [23:0] s,
                                                logic [15:0] st, logic lst);
        particle_t p;
        p.px = x; p.py = y; p.pz = z;
        p.age = a; p.life = l; p.speed = s; p.step = st; p.last = lst;
        p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
        return p;
    endfunction

    function automatic logic [31:0] rand_coord(longint pivot);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h7fffffff - $urandom_range(0, 3);
        if (r == 1) return 32'h80000000 + $urandom_range(0, 3);
        if (r == 2) return 32'(pivot) + $urandom_range(0, 8) - 4;
        return $urandom;
    endfunction

    // one time step of random particles ending in a final word
    task automatic send_random_step(int count, logic dying);
        particle_t p;
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            p.px = rand_coord(pv_x);
            p.py = rand_coord(pv_y);
            p.pz = rand_coord(pv_z);
            p.speed = $urandom_range(0, 9) == 0 ? 24'hffffff : 24'($urandom);
            p.step = $urandom_range(0, 9) == 0 ? 16'hffff : 16'($urandom);
            a = $urandom_range(0, 9) == 0 ? 32'hffffffff - $urandom_range(0, 70000) : $urandom;
            p.age = a;
            if (dying || $urandom_range(0, 3) == 0)
                p.life = $urandom_range(0, 3) == 0 ? 32'd0 : a;
            else if ($urandom_range(0, 1) == 0)
                p.life = a + $urandom_range(0, 2 * p.step + 1);
            else
                p.life = $urandom;
            p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
            p.last = (i == count - 1) || ($urandom_range(0, 40) == 0);
            send_particle(p);
        end
    endtask

    task automatic test_drop_extremes();
        set_config(32'd0, 32'd0, 32'd0, 1'b0, pmlu_pkg::MODE_DROP);
        send_particle(make_particle(32'h0, 32'h80000000, 32'h0, 32'h0, 32'hffffffff,
                                    24'hffffff, 16'hffff, 1'b0));
        send_particle(make_particle(32'h7fffffff, 32'h7fffffff, 32'hffffffff,
                                    32'hffffffff, 32'hffffffff, 24'hffffff, 16'hffff, 1'b0));
        send_particle(make_particle(32'h80000000, 32'h0, 32'h7fffffff, 32'h10, 32'h5,
                                    24'h0, 16'h0, 1'b1));
        send_particle(make_particle(32'h1, 32'h12345678, 32'h2, 32'h0, 32'h0,
                                    24'h010000, 16'h8000, 1'b1));
    endtask

    task automatic test_spread_pivot();
        set_config(32'h00010000, 32'hfffe0000, 32'h7fffffff, 1'b0, pmlu_pkg::MODE_SPREAD);
        // particle at the pivot stays put
        send_particle(make_particle(32'h00010000, 32'hfffe0000, 32'h7fffffff, 32'h0,
                                    32'h100000, 24'hffffff, 16'hffff, 1'b0));
        send_particle(make_particle(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0,
                                    32'h100000, 24'hffffff, 16'hffff, 1'b0));
        send_particle(make_particle(32'h00020000, 32'hfffe0000, 32'h7fffffff, 32'h0,
                                    32'h0, 24'h123456, 16'h4000, 1'b1));
        set_config(32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0, pmlu_pkg::MODE_SPREAD);
        send_particle(make_particle(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h0,
                                    32'h100000, 24'hffffff, 16'hffff, 1'b1));
    endtask

    task automatic test_burst_loop();
        set_config(32'h0, 32'h0, 32'h0, 1'b1, pmlu_pkg::MODE_BURST);
        // respawn takes the spawn position
        send_particle(make_particle(32'h00050000, 32'h00030000, 32'h0, 32'h00010000,
                                    32'h00010000, 24'h020000, 16'h1000, 1'b1));
        send_particle(make_particle(32'h00050000, 32'h0, 32'h0, 32'h0, 32'h00100000,
                                    24'h020000, 16'h1000, 1'b1));
        send_particle(make_particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 24'hffffff,
                                    16'hffff, 1'b1));
        write_reg(pmlu_pkg::CFG_MOTION_MODE, {30'd0, pmlu_pkg::MODE_UNUSED});
        send_particle(make_particle(32'hffff0000, 32'h00070000, 32'h12340000, 32'h0,
                                    32'h00100000, 24'h0abcde, 16'h2222, 1'b0));
        send_particle(make_particle(32'h80000000, 32'h80000000, 32'h80000000, 32'hfffffff0,
                                    32'hffffffff, 24'hffffff, 16'hffff, 1'b1));
        write_reg(pmlu_pkg::CFG_MOTION_MODE, {30'd0, pmlu_pkg::MODE_SPREAD});
        send_particle(make_particle(32'h00050000, 32'h0, 32'h0, 32'h0, 32'h00100000,
                                    24'h020000, 16'h1000, 1'b1));
        write_reg(pmlu_pkg::CFG_MOTION_MODE, {30'd0, pmlu_pkg::MODE_DROP});
        send_particle(make_particle(32'h00050000, 32'h0, 32'h0, 32'h0, 32'h00100000,
                                    24'h020000, 16'h1000, 1'b1));
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        set_config($urandom, $urandom, $urandom, 1'b0, pmlu_pkg::MODE_BURST);
        send_random_step(30, 1'b0);
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_random_phases();
        logic [MODE_W-1:0] m;
        for (int ph = 0; ph < 8; ph++)
        begin
            m = MODE_W'($urandom_range(0, 3));
            set_config(ph == 0 ? 32'h7fffffff : $urandom,
                       ph == 1 ? 32'h80000000 : $urandom,
                       $urandom_range(0, 3) == 0 ? 32'h0 : $urandom,
                       1'($urandom_range(0, 1)), m);
            for (int g = 0; g < 14; g++)
                send_random_step($urandom_range(1, 15), $urandom_range(0, 3) == 0);
        end
    endtask

    initial
    begin
        pv_x = 0; pv_y = 0; pv_z = 0;
        loop_en = 1'b0;
        mode = pmlu_pkg::MODE_DROP;
        alive_acc = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_drop_extremes();
        test_spread_pivot();
        test_burst_loop();
        test_back_to_back();
        test_random_phases();
        wait_drained();
        $display("sent %0d particle words, checked %0d results", words_sent, words_checked);
        $display("covered drop, spread, burst and unused mode, looping on and off");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- particle_motion_lifetime_update.f -----
design/pmlu_pkg.sv
design/pmlu_sqrt.sv
design/pmlu_div.sv
design/particle_motion_lifetime_update.sv
bench/tb.sv
